FILE: rtl/core/utf8_printable_name_check_assert.svh
// Assertion macros for the printable UTF-8 string checker.
// Used by the top level only; no other dependencies.
`ifndef UTF8_PRINTABLE_NAME_CHECK_ASSERT_SVH
`define UTF8_PRINTABLE_NAME_CHECK_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define UPC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset
`define UPC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/utf8pc_pkg.sv
// Types and constants shared by the printable UTF-8 checker.
// No dependencies.
package utf8pc_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [9:0]  max_bytes_type;
   typedef logic [20:0] code_type;
   typedef logic [10:0] count_type;

   // Per-string decoder state
   typedef struct packed {
      logic [1:0] pend;
      code_type   acc;
      logic [1:0] min_class;
      logic       failed;
      logic       seen_visible;
      count_type  count;
   } str_state_type;

   localparam max_bytes_type MAX_BYTES_RESET = 10'd64;
   localparam count_type     COUNT_MAX       = 11'h7FF;

   localparam code_type CP_MAX        = 21'h10FFFF;
   localparam code_type CP_SURR_LO    = 21'h00D800;
   localparam code_type CP_SURR_HI    = 21'h00DFFF;
   localparam code_type CP_SPACE      = 21'h000020;
   localparam code_type CP_DEL        = 21'h00007F;
   localparam code_type CP_C1_HI      = 21'h00009F;
   localparam code_type CP_ZW_LO      = 21'h00200B;
   localparam code_type CP_ZW_HI      = 21'h00200F;
   localparam code_type CP_SEP_LO     = 21'h002028;
   localparam code_type CP_SEP_HI     = 21'h00202E;
   localparam code_type CP_WJ_LO      = 21'h002060;
   localparam code_type CP_WJ_HI      = 21'h00206F;
   localparam code_type CP_BOM        = 21'h00FEFF;

   localparam byte_type LEAD2_LO = 8'hC2;
   localparam byte_type LEAD2_HI = 8'hDF;
   localparam byte_type LEAD3_LO = 8'hE0;
   localparam byte_type LEAD3_HI = 8'hEF;
   localparam byte_type LEAD4_LO = 8'hF0;
   localparam byte_type LEAD4_HI = 8'hF4;

   // Minimum-value classes for the overlong check
   localparam logic [1:0] CLASS_ASCII = 2'd0;
   localparam logic [1:0] CLASS_TWO   = 2'd1;
   localparam logic [1:0] CLASS_THREE = 2'd2;
   localparam logic [1:0] CLASS_FOUR  = 2'd3;

endpackage

FILE: rtl/core/utf8pc_req_if.sv
// Request channel: one string byte plus end-of-string marker.
// Depends on utf8pc_pkg.
interface utf8pc_req_if;
   import utf8pc_pkg::*;

   logic     valid;
   logic     ready;
   byte_type data_byte;
   logic     last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: rtl/core/utf8pc_rsp_if.sv
// Response channel: one verdict per string.
// No dependencies.
interface utf8pc_rsp_if;
   logic valid;
   logic ready;
   logic valid_res;

   modport source (output valid, output valid_res, input ready);
   modport sink (input valid, input valid_res, output ready);
endinterface

FILE: rtl/core/utf8pc_decode.sv
// Combinational per-byte update of the UTF-8 decoder state and verdict.
// Depends on utf8pc_pkg.
module utf8pc_decode (
   input  utf8pc_pkg::str_state_type state_cur,
   input  utf8pc_pkg::byte_type      data_byte,
   input  logic                      last_byte,
   input  utf8pc_pkg::max_bytes_type max_bytes,
   output utf8pc_pkg::str_state_type state_nxt,
   output logic                      verdict
);
   import utf8pc_pkg::*;

   // Code point rejection test, including the overlong check
   function automatic logic cp_bad(input code_type cp, input logic [1:0] cls);
      code_type min_cp;
      case (cls)
         CLASS_TWO:   min_cp = 21'h000080;
         CLASS_THREE: min_cp = 21'h000800;
         CLASS_FOUR:  min_cp = 21'h010000;
         default:     min_cp = '0;
      endcase
      return (cp < min_cp) || (cp > CP_MAX) ||
             (cp >= CP_SURR_LO && cp <= CP_SURR_HI) ||
             (cp < CP_SPACE) ||
             (cp >= CP_DEL && cp <= CP_C1_HI) ||
             (cp >= CP_ZW_LO && cp <= CP_ZW_HI) ||
             (cp >= CP_SEP_LO && cp <= CP_SEP_HI) ||
             (cp >= CP_WJ_LO && cp <= CP_WJ_HI) ||
             (cp == CP_BOM);
   endfunction

   str_state_type upd;
   code_type      cp;
   logic [1:0]    cls;
   logic          judge;

   always_comb begin
      upd   = state_cur;
      cp    = '0;
      cls   = CLASS_ASCII;
      judge = 1'b0;

      // saturating length count
      if (state_cur.count != COUNT_MAX) begin
         upd.count = state_cur.count + 11'd1;
      end

      if (state_cur.pend == 2'd0) begin
         // expecting a lead byte or ASCII
         if (!data_byte[7]) begin
            cp    = {13'd0, data_byte};
            judge = 1'b1;
         end else if (data_byte >= LEAD2_LO && data_byte <= LEAD2_HI) begin
            upd.acc       = {16'd0, data_byte[4:0]};
            upd.min_class = CLASS_TWO;
            upd.pend      = 2'd1;
         end else if (data_byte >= LEAD3_LO && data_byte <= LEAD3_HI) begin
            upd.acc       = {17'd0, data_byte[3:0]};
            upd.min_class = CLASS_THREE;
            upd.pend      = 2'd2;
         end else if (data_byte >= LEAD4_LO && data_byte <= LEAD4_HI) begin
            upd.acc       = {18'd0, data_byte[2:0]};
            upd.min_class = CLASS_FOUR;
            upd.pend      = 2'd3;
         end else begin
            upd.failed = 1'b1;
         end
      end else if (data_byte[7:6] != 2'b10) begin
         // broken sequence: drop it
         upd.failed    = 1'b1;
         upd.pend      = 2'd0;
         upd.acc       = '0;
         upd.min_class = CLASS_ASCII;
      end else begin
         upd.acc  = {state_cur.acc[14:0], data_byte[5:0]};
         upd.pend = state_cur.pend - 2'd1;
         if (upd.pend == 2'd0) begin
            cp            = upd.acc;
            cls           = state_cur.min_class;
            judge         = 1'b1;
            upd.acc       = '0;
            upd.min_class = CLASS_ASCII;
         end
      end

      // judge a completed code point
      if (judge) begin
         if (cp_bad(cp, cls)) begin
            upd.failed = 1'b1;
         end else if (cp != CP_SPACE) begin
            upd.seen_visible = 1'b1;
         end
      end

      verdict = !upd.failed && (upd.pend == 2'd0) && upd.seen_visible &&
                (upd.count <= {1'b0, max_bytes});

      // end of string clears everything
      if (last_byte) begin
         state_nxt = '0;
      end else begin
         state_nxt = upd;
      end
   end

endmodule

FILE: rtl/core/utf8_printable_name_check.sv
// Printable UTF-8 string checker. The verdict is registered, and valid on rsp, when the
// byte register advances with the last byte. Throughput: one byte per cycle while no
// verdict stalls; the decoder update between the two registers is combinational.
// A stalled verdict holds only the stage behind it when that stage holds a last byte.
// Reset (synchronous, active high) clears string state, empties both stages and
// sets max_bytes to 64.
module utf8_printable_name_check (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  utf8pc_pkg::max_bytes_type csr_wr_data,
   utf8pc_req_if.sink                req_chan,
   utf8pc_rsp_if.source              rsp_chan
);
   import utf8pc_pkg::*;

   `include "utf8_printable_name_check_assert.svh"

   max_bytes_type max_bytes_ff;
   logic          s1_valid_ff;
   byte_type      s1_byte_ff;
   logic          s1_last_ff;
   str_state_type state_ff;
   str_state_type state_in;
   logic          rsp_valid_ff;
   logic          rsp_data_ff;
   logic          verdict;
   logic          out_free;
   logic          s1_advance;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= MAX_BYTES_RESET;
      end else if (csr_wr_en) begin
         max_bytes_ff <= csr_wr_data;
      end
   end

   // handshake control
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign s1_advance     = s1_valid_ff && (out_free || !s1_last_ff);
   assign req_chan.ready = !s1_valid_ff || s1_advance;

   // input byte register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_byte_ff <= req_chan.data_byte;
         s1_last_ff <= req_chan.last_byte;
      end
   end

   utf8pc_decode u_decode (
      .state_cur (state_ff),
      .data_byte (s1_byte_ff),
      .last_byte (s1_last_ff),
      .max_bytes (max_bytes_ff),
      .state_nxt (state_in),
      .verdict   (verdict)
   );

   // string state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (s1_advance) begin
         state_ff <= state_in;
      end
   end

   // verdict register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance && s1_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_last_ff) begin
         rsp_data_ff <= verdict;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.valid_res = rsp_data_ff;

   // checks
   `UPC_ASSERT_NEXT(a_verdict_loaded, s1_advance && s1_last_ff, rsp_valid_ff && (rsp_data_ff == $past(verdict)), "verdict not registered after last byte")
   `UPC_ASSERT_NOW(a_no_overwrite, rsp_valid_ff && !rsp_chan.ready && s1_valid_ff && s1_last_ff, !s1_advance, "pending verdict overwritten")
   `UPC_ASSERT_NEXT(a_state_cleared, s1_advance && s1_last_ff, (state_ff.count == '0) && (state_ff.pend == 2'd0) && !state_ff.failed, "string state not cleared")
   `UPC_ASSERT_NEXT(a_fail_sticky, s1_advance && !s1_last_ff && state_ff.failed, state_ff.failed, "error flag dropped mid-string")

endmodule

FILE: sim/tb_utf8_printable_name_check.sv
// Testbench for the printable UTF-8 string checker: a directed table, then random
// strings, checked against a behavioural decoder. Needs utf8pc_pkg and the RTL.
module tb_utf8_printable_name_check;
   timeunit 1ns;
   timeprecision 1ps;
   import utf8pc_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int LONG_HOLD      = 80;
   localparam int PHASE_ITEMS    = 60;
   localparam int PHASE_COUNT    = 9;

   // Directed table rows: byte, end of string, verdict typed in or computed
   typedef struct packed {
      byte_type data;
      logic     last;
      logic     typed;
      logic     verdict;
   } dir_row_type;

   localparam logic MORE  = 1'b0;
   localparam logic FIN   = 1'b1;
   localparam logic CALC  = 1'b0;
   localparam logic TYPED = 1'b1;
   localparam int DIR_ROWS = 26;

   localparam dir_row_type [0:DIR_ROWS-1] DIRECTED_ROWS = {
      {8'h41, FIN,  TYPED, 1'b1},   // plain letter
      {8'h20, FIN,  TYPED, 1'b0},   // nothing but a space
      {8'h00, FIN,  TYPED, 1'b0},   // NUL control
      {8'hFF, FIN,  TYPED, 1'b0},   // bad lead byte
      {8'hC2, MORE, CALC,  1'b0},   // U+0080, a C1 control
      {8'h80, FIN,  TYPED, 1'b0},
      {8'hDF, MORE, CALC,  1'b0},   // U+07FF, top of the two-byte range
      {8'hBF, FIN,  CALC,  1'b0},
      {8'hED, MORE, CALC,  1'b0},   // U+D800, surrogate
      {8'hA0, MORE, CALC,  1'b0},
      {8'h80, FIN,  TYPED, 1'b0},
      {8'hE2, MORE, CALC,  1'b0},   // U+200B, zero width space
      {8'h80, MORE, CALC,  1'b0},
      {8'h8B, FIN,  CALC,  1'b0},
      {8'hF4, MORE, CALC,  1'b0},   // U+10FFFF, highest code point
      {8'h8F, MORE, CALC,  1'b0},
      {8'hBF, MORE, CALC,  1'b0},
      {8'hBF, FIN,  TYPED, 1'b1},
      {8'hF4, MORE, CALC,  1'b0},   // U+110000, beyond the code space
      {8'h90, MORE, CALC,  1'b0},
      {8'h80, MORE, CALC,  1'b0},
      {8'h80, FIN,  TYPED, 1'b0},
      {8'hE2, MORE, CALC,  1'b0},   // sequence cut short by the end of string
      {8'h82, FIN,  TYPED, 1'b0},
      {8'hC2, MORE, CALC,  1'b0},   // continuation replaced by a letter
      {8'h41, FIN,  TYPED, 1'b0}
   };

   logic          clock;
   logic          reset;
   logic          csr_wr_en;
   max_bytes_type csr_wr_data;

   utf8pc_req_if req_if ();
   utf8pc_rsp_if rsp_if ();

   utf8_printable_name_check u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if)
   );

   // Decoder mirror: length limit and per-string state
   max_bytes_type max_len;
   logic [1:0]    cont_left;
   code_type      cp_acc;
   logic [1:0]    lo_class;
   logic          err_seen;
   logic          has_glyph;
   count_type     nbytes;

   logic     expected_verdicts[$];
   byte_type text_q[$];
   int       fail_count   = 0;
   int       items_sent   = 0;
   int       stall_cycles = 0;
   bit       req_quiet    = 1'b0;
   bit       rsp_quiet    = 1'b0;
   bit       hold_req     = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void clear_string();
      cont_left = 2'd0;
      cp_acc    = '0;
      lo_class  = CLASS_ASCII;
      err_seen  = 1'b0;
      has_glyph = 1'b0;
      nbytes    = '0;
   endfunction

   function automatic logic code_rejected(code_type cp, logic [1:0] cls);
      code_type floor_cp;
      case (cls)
         CLASS_TWO:   floor_cp = 21'h80;
         CLASS_THREE: floor_cp = 21'h800;
         CLASS_FOUR:  floor_cp = 21'h10000;
         default:     floor_cp = 21'h0;
      endcase
      return cp < floor_cp || cp > CP_MAX ||
             (cp >= CP_SURR_LO && cp <= CP_SURR_HI) || cp < CP_SPACE ||
             (cp >= CP_DEL && cp <= CP_C1_HI) ||
             (cp >= CP_ZW_LO && cp <= CP_ZW_HI) ||
             (cp >= CP_SEP_LO && cp <= CP_SEP_HI) ||
             (cp >= CP_WJ_LO && cp <= CP_WJ_HI) || cp == CP_BOM;
   endfunction

   function automatic void judge_code(code_type cp, logic [1:0] cls);
      if (code_rejected(cp, cls))
         err_seen = 1'b1;
      else if (cp != CP_SPACE)
         has_glyph = 1'b1;
   endfunction

   // Advance the mirror by one byte; at the end of a string queue the verdict.
   // A verdict typed into the table (forced >= 0) takes the place of the computed one.
   function automatic void decode_byte(byte_type b, logic last, int forced);
      logic ok;
      if (nbytes != COUNT_MAX)
         nbytes = nbytes + 11'd1;
      if (cont_left == 2'd0) begin
         if (b < 8'h80) begin
            judge_code({13'd0, b}, CLASS_ASCII);
         end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
            cp_acc    = {16'd0, b[4:0]};
            lo_class  = CLASS_TWO;
            cont_left = 2'd1;
         end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
            cp_acc    = {17'd0, b[3:0]};
            lo_class  = CLASS_THREE;
            cont_left = 2'd2;
         end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
            cp_acc    = {18'd0, b[2:0]};
            lo_class  = CLASS_FOUR;
            cont_left = 2'd3;
         end else begin
            err_seen = 1'b1;
         end
      end else if (b[7:6] != 2'b10) begin
         err_seen  = 1'b1;
         cont_left = 2'd0;
         cp_acc    = '0;
         lo_class  = CLASS_ASCII;
      end else begin
         cp_acc    = {cp_acc[14:0], b[5:0]};
         cont_left = cont_left - 2'd1;
         if (cont_left == 2'd0) begin
            judge_code(cp_acc, lo_class);
            cp_acc   = '0;
            lo_class = CLASS_ASCII;
         end
      end
      if (last) begin
         ok = !err_seen && cont_left == 2'd0 && has_glyph && nbytes <= {1'b0, max_len};
         expected_verdicts.insert(expected_verdicts.size(), (forced >= 0) ? forced[0] : ok);
         clear_string();
      end
   endfunction

   function automatic int pick_gap(bit quiet);
      int r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Stimulus helpers: code point choice and encoding
   function automatic code_type random_code();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return code_type'($urandom_range(8'h21, 8'h7E));
         4:          return code_type'($urandom_range(0, 8'h7F));
         5:          return code_type'($urandom_range(21'h80, 21'h7FF));
         6, 7:       return code_type'($urandom_range(21'h800, 21'hFFFF));
         8:          return code_type'($urandom_range(21'h10000, 21'h10FFFF));
         default:    return code_type'($urandom_range(21'h110000, 21'h1FFFFF));
      endcase
   endfunction

   function automatic code_type boundary_code();
      case ($urandom_range(0, 29))
         0:  return 21'h1F;     1:  return 21'h20;     2:  return 21'h7E;
         3:  return 21'h7F;     4:  return 21'h9F;     5:  return 21'hA0;
         6:  return 21'h7FF;    7:  return 21'h800;    8:  return 21'hD7FF;
         9:  return 21'hD800;   10: return 21'hDFFF;   11: return 21'hE000;
         12: return 21'h200A;   13: return 21'h200B;   14: return 21'h200F;
         15: return 21'h2010;   16: return 21'h2027;   17: return 21'h2028;
         18: return 21'h202E;   19: return 21'h202F;   20: return 21'h205F;
         21: return 21'h2060;   22: return 21'h206F;   23: return 21'h2070;
         24: return 21'hFEFE;   25: return 21'hFEFF;   26: return 21'hFFFF;
         27: return 21'h10000;  28: return 21'h10FFFF;
         default: return 21'h110000;
      endcase
   endfunction

   function automatic int utf8_len(code_type cp);
      if (cp < 21'h80)
         return 1;
      if (cp < 21'h800)
         return 2;
      if (cp < 21'h10000)
         return 3;
      return 4;
   endfunction

   // Append one byte to the string under construction
   function automatic void put_byte(byte_type b);
      text_q.insert(text_q.size(), b);
   endfunction

   // Encode with nb bytes; more bytes than needed gives an overlong form
   function automatic void encode_char(code_type cp, int nb);
      case (nb)
         1: put_byte(cp[7:0]);
         2: begin
            put_byte({3'b110, cp[10:6]});
            put_byte({2'b10, cp[5:0]});
         end
         3: begin
            put_byte({4'b1110, cp[15:12]});
            put_byte({2'b10, cp[11:6]});
            put_byte({2'b10, cp[5:0]});
         end
         default: begin
            put_byte({5'b11110, cp[20:18]});
            put_byte({2'b10, cp[17:12]});
            put_byte({2'b10, cp[11:6]});
            put_byte({2'b10, cp[5:0]});
         end
      endcase
   endfunction

   // One character: clean strings keep to proper encodings, others get damage too
   function automatic void add_char(bit clean);
      code_type cp;
      int       nb;
      int       pick;
      byte_type junk;
      pick = clean ? $urandom_range(0, 74) : $urandom_range(0, 99);
      cp   = random_code();
      nb   = utf8_len(cp);
      if (pick < 55) begin
         encode_char(cp, nb);
      end else if (pick < 65) begin
         put_byte(8'h20);
      end else if (pick < 75) begin
         cp = boundary_code();
         encode_char(cp, utf8_len(cp));
      end else if (pick < 82) begin
         encode_char(cp, (nb < 4) ? $urandom_range(nb + 1, 4) : 4);
      end else if (pick < 88) begin
         // sequence truncated by one or more continuation bytes
         if (nb == 1) begin
            cp = code_type'($urandom_range(21'h80, 21'hFFFF));
            nb = utf8_len(cp);
         end
         encode_char(cp, nb);
         repeat ($urandom_range(1, nb - 1))
            junk = text_q.pop_back();
      end else if (pick < 94) begin
         put_byte(byte_type'($urandom_range(0, 255)));
      end else begin
         // final continuation replaced by a byte outside 10xxxxxx
         encode_char(cp, (nb < 2) ? 2 : nb);
         junk = byte_type'($urandom);
         if (junk[7:6] == 2'b10)
            junk[6] = 1'b1;
         text_q[text_q.size() - 1] = junk;
      end
   endfunction

   function automatic void build_string(int max_chars);
      int n;
      bit clean;
      text_q.delete();
      clean = ($urandom_range(0, 9) < 7);
      n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, max_chars)
                                      : $urandom_range(max_chars, 3 * max_chars);
      repeat (n)
         add_char(clean);
   endfunction

   function automatic void fill_printable(int len);
      text_q.delete();
      repeat (len)
         put_byte(byte_type'($urandom_range(8'h21, 8'h7E)));
   endfunction

   // Offer one byte after a random gap and wait for the request to be taken
   task automatic push_byte(byte_type b, logic last, int forced);
      int gap;
      gap = pick_gap(req_quiet);
      repeat (gap) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
      @(negedge clock);
      req_if.valid     <= 1'b1;
      req_if.data_byte <= b;
      req_if.last_byte <= last;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      decode_byte(b, last, forced);
      items_sent++;
   endtask

   task automatic send_text();
      int i;
      for (i = 0; i < text_q.size(); i++)
         push_byte(text_q[i], i == text_q.size() - 1, -1);
   endtask

   task automatic release_req();
      @(negedge clock);
      req_if.valid <= 1'b0;
   endtask

   // Block is idle once every verdict is in; the task then lets the clock run on before returning
   task automatic wait_idle();
      while (expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_limit(int value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= max_bytes_type'(value);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      max_len = max_bytes_type'(value);
   endtask

   // Verdict receiver: random stalls, plus one long hold-off on request
   initial begin
      int gap;
      rsp_if.ready = 1'b0;
      forever begin
         if (hold_req) begin
            repeat (LONG_HOLD) begin
               @(negedge clock);
               rsp_if.ready <= 1'b0;
            end
            hold_req = 1'b0;
         end
         gap = pick_gap(rsp_quiet);
         repeat (gap) begin
            @(negedge clock);
            rsp_if.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_if.ready <= 1'b1;
      end
   end

   // Compare each verdict with the oldest one predicted
   always @(posedge clock) begin : check_verdicts
      logic want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_verdicts.size() == 0) begin
            $display("%0t: verdict with none expected, got %0b", $time, rsp_if.valid_res);
            fail_count++;
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_if.valid_res !== want) begin
               $display("%0t: verdict mismatch, expected %0b, got %0b",
                        $time, want, rsp_if.valid_res);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on cycles with no request or verdict taken
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, stall_cycles);
         $display("simulation failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Main sequence: reset, directed table, then phases at different limits
   initial begin
      int          ph;
      int          lim;
      int          start;
      int          row;
      dir_row_type cur;
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      req_if.valid     = 1'b0;
      req_if.data_byte = '0;
      req_if.last_byte = 1'b0;
      max_len          = MAX_BYTES_RESET;
      clear_string();
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // directed part at the reset limit of 64
      for (row = 0; row < DIR_ROWS; row++) begin
         cur = DIRECTED_ROWS[row];
         push_byte(cur.data, cur.last, cur.typed ? int'(cur.verdict) : -1);
      end
      release_req();

      for (ph = 0; ph < PHASE_COUNT; ph++) begin
         case (ph)
            0:       lim = 1023;
            1:       lim = 1;
            2:       lim = 0;
            3:       lim = 64;
            8:       lim = $urandom_range(41, 1023);
            default: lim = $urandom_range(2, 40);
         endcase
         wait_idle();
         write_limit(lim);
         req_quiet = (ph % 3 == 1);
         rsp_quiet = (ph % 3 == 2);

         if (ph == 0) begin
            // one byte over the largest limit
            fill_printable(1024);
            send_text();
         end
         if (ph == 3) begin
            // receiver holds off while one-byte strings keep coming
            req_quiet = 1'b1;
            hold_req  = 1'b1;
            repeat (24) begin
               fill_printable(1);
               send_text();
            end
            req_quiet = 1'b0;
         end

         start = items_sent;
         while (items_sent - start < PHASE_ITEMS) begin
            if (lim <= 64 && $urandom_range(0, 7) == 0)
               fill_printable((lim < 2) ? $urandom_range(1, 2) : $urandom_range(lim - 1, lim + 1));
            else
               build_string(($urandom_range(0, 9) == 0) ? 20 : 6);
            send_text();
         end
         release_req();
      end

      while (expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

FILE: utf8_printable_name_check.f
+incdir+rtl/core
rtl/core/utf8pc_pkg.sv
rtl/core/utf8pc_req_if.sv
rtl/core/utf8pc_rsp_if.sv
rtl/core/utf8pc_decode.sv
rtl/core/utf8_printable_name_check.sv
sim/tb_utf8_printable_name_check.sv
